// ----- design/tga_rle_row_decoder_macros.svh -----
// Assertion macros used by the decoder checker.
`ifndef TGA_RLE_ROW_DECODER_MACROS_SVH
`define TGA_RLE_ROW_DECODER_MACROS_SVH

// Checked only outside reset.
`define TRD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tga_rle_row_decoder: assertion failed");

// Checked at every edge, reset included.
`define TRD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tga_rle_row_decoder: assertion failed");

`endif

// ----- design/trd_pkg.sv -----
// Types, constants and register codes of the TGA run-length row decoder.
`timescale 1ns / 1ps

package trd_pkg;

  localparam int BYTE_W       = 8;
  localparam int PIXEL_W      = 32;
  localparam int COUNT_W      = 8;
  localparam int COLUMN_W     = 16;
  localparam int BPP_W        = 3;
  localparam int BYTE_IDX_W   = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;

  localparam logic [6:0] COUNT_MASK  = 7'h7F;
  localparam logic [7:0] REPEAT_FLAG = 8'h80;

  localparam logic [BPP_W-1:0]    BPP_RESET       = 3'd4;
  localparam logic [COLUMN_W-1:0] ROW_WIDTH_RESET = 16'd640;

  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH       = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER = 2'b01,
    PH_PIXEL  = 2'b10
  } phase_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_value;
    logic [COUNT_W-1:0] repeat_count;
    logic               row_end;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

// ----- design/trd_stream_if.sv -----
// Valid/ready stream interfaces for the decoder input bytes and output pixels.
`timescale 1ns / 1ps

interface trd_in_if;
  import trd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              frame_start;

  modport source (output valid, data_byte, frame_start, input ready);
  modport sink   (input valid, data_byte, frame_start, output ready);
endinterface

interface trd_out_if;
  import trd_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_value;
  logic [COUNT_W-1:0] repeat_count;
  logic               row_end;

  modport source (output valid, pixel_value, repeat_count, row_end, input ready);
  modport sink   (input valid, pixel_value, repeat_count, row_end, output ready);
endinterface

// ----- design/trd_out_buf.sv -----
// Output register with a skid stage, so the input side stalls only once both hold data.
`timescale 1ns / 1ps

module trd_out_buf #(
  parameter int DATA_W = trd_pkg::RESULT_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  logic [DATA_W-1:0] push_data,
  output logic              push_ready,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);
  import trd_pkg::*;

  logic              main_valid;
  logic [DATA_W-1:0] main_data;
  logic              skid_valid;
  logic [DATA_W-1:0] skid_data;
  logic              pop;
  logic              push;

  assign push_ready = !skid_valid;
  assign pop_valid  = main_valid;
  assign pop_data   = main_data;
  assign pop        = main_valid && pop_ready;
  assign push       = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      // refill from the skid stage if it holds a request
      main_valid <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!main_valid || pop) begin
        main_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end else if (pop && skid_valid) begin
      main_data <= skid_data;
    end
  end

endmodule

// ----- design/tga_rle_row_decoder.sv -----
// TGA run-length row decoder: packet state machine, column tracking and pixel assembly.
// A result is pushed into the output buffer as the byte that completes it is accepted.
// Throughput: one stream byte per cycle; input stalls only while the output
// register and its skid stage both hold undelivered pixels.
// Reset (rst, synchronous): decoder waits for a header at column zero,
// bytes_per_pixel = 4, row_width = 640, output empty.
`timescale 1ns / 1ps

module tga_rle_row_decoder (
  input  logic                             clk,
  input  logic                             rst,
  trd_in_if.sink                           in_ch,
  trd_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [trd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [trd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import trd_pkg::*;

  logic [BPP_W-1:0]      bytes_per_pixel;
  logic [COLUMN_W-1:0]   row_width;

  phase_t                phase, phase_next;
  logic                  packet_is_repeat, packet_is_repeat_next;
  logic [COUNT_W-1:0]    pixels_left, pixels_left_next;
  logic [BYTE_IDX_W-1:0] byte_index, byte_index_next;
  logic [PIXEL_W-1:0]    pixel_acc, pixel_acc_next;
  logic [COLUMN_W-1:0]   column, column_next;

  // state after an optional frame restart
  phase_t                ph;
  logic                  rep;
  logic [COUNT_W-1:0]    left;
  logic [BYTE_IDX_W-1:0] bi;
  logic [PIXEL_W-1:0]    acc;
  logic [COLUMN_W-1:0]   col;

  logic [BPP_W-1:0]      pixel_size;
  logic [PIXEL_W-1:0]    acc_merged;
  logic [COUNT_W-1:0]    copies;
  logic [COLUMN_W-1:0]   room;
  logic [COUNT_W-1:0]    clipped;
  logic [COLUMN_W-1:0]   col_sum;

  logic                  accept;
  logic                  res_valid;
  result_t               res;
  logic [RESULT_W-1:0]   res_bits;

  assign accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= BPP_RESET;
      row_width       <= ROW_WIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[BPP_W-1:0];
        REG_ROW_WIDTH:       row_width       <= cfg_data[COLUMN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bytes_per_pixel == 3'd0) begin
      pixel_size = 3'd1;
    end else if (bytes_per_pixel > 3'd4) begin
      pixel_size = 3'd4;
    end else begin
      pixel_size = bytes_per_pixel;
    end
  end

  always_comb begin
    ph   = in_ch.frame_start ? PH_HEADER : phase;
    rep  = in_ch.frame_start ? 1'b0 : packet_is_repeat;
    left = in_ch.frame_start ? '0 : pixels_left;
    bi   = in_ch.frame_start ? '0 : byte_index;
    acc  = in_ch.frame_start ? '0 : pixel_acc;
    col  = in_ch.frame_start ? '0 : column;

    acc_merged = acc | ({{(PIXEL_W-BYTE_W){1'b0}}, in_ch.data_byte} << {bi, 3'b000});
    copies     = rep ? left : 8'd1;
    room       = (col < row_width) ? (row_width - col) : '0;
    clipped    = ({8'd0, copies} > room) ? room[COUNT_W-1:0] : copies;
    col_sum    = col + {8'd0, clipped};

    phase_next            = ph;
    packet_is_repeat_next = rep;
    pixels_left_next      = left;
    byte_index_next       = bi;
    pixel_acc_next        = acc;
    column_next           = col;
    res_valid             = 1'b0;
    res.pixel_value       = acc_merged;
    res.repeat_count      = clipped;
    res.row_end           = (col_sum == row_width);

    unique case (ph)
      PH_HEADER: begin
        pixels_left_next      = {1'b0, in_ch.data_byte[6:0] & COUNT_MASK} + 8'd1;
        packet_is_repeat_next = (in_ch.data_byte & REPEAT_FLAG) != 8'd0;
        byte_index_next       = '0;
        pixel_acc_next        = '0;
        phase_next            = PH_PIXEL;
      end
      PH_PIXEL: begin
        if (({1'b0, bi} + 3'd1) < pixel_size) begin
          pixel_acc_next  = acc_merged;
          byte_index_next = bi + 2'd1;
        end else begin
          res_valid   = (clipped != 8'd0);
          column_next = col_sum;
          byte_index_next = '0;
          pixel_acc_next  = '0;
          if (rep || left <= 8'd1) begin
            // packet over: wrap to a new row once this one is full
            if (col_sum >= row_width) column_next = '0;
            phase_next       = PH_HEADER;
            pixels_left_next = '0;
          end else begin
            pixels_left_next = left - 8'd1;
          end
        end
      end
      default: phase_next = PH_HEADER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      packet_is_repeat <= 1'b0;
      pixels_left      <= '0;
      byte_index       <= '0;
      pixel_acc        <= '0;
      column           <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      packet_is_repeat <= packet_is_repeat_next;
      pixels_left      <= pixels_left_next;
      byte_index       <= byte_index_next;
      pixel_acc        <= pixel_acc_next;
      column           <= column_next;
    end
  end

  assign res_bits = res;

  trd_out_buf #(
    .DATA_W (RESULT_W)
  ) u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (accept && res_valid),
    .push_data  (res_bits),
    .push_ready (in_ch.ready),
    .pop_valid  (out_ch.valid),
    .pop_ready  (out_ch.ready),
    .pop_data   ({out_ch.pixel_value, out_ch.repeat_count, out_ch.row_end})
  );

endmodule

// ----- design/trd_checker.sv -----
// Port-level checks of the TGA run-length row decoder, bound to the top level.
`timescale 1ns / 1ps
`include "tga_rle_row_decoder_macros.svh"

module trd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [trd_pkg::PIXEL_W-1:0]     pixel_value,
  input logic [trd_pkg::COUNT_W-1:0]     repeat_count
);
  import trd_pkg::*;

  // a held pixel stays put until taken
  `TRD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(pixel_value))

  // the input only stalls while a pixel waits at the output
  `TRD_ASSERT(a_stall_has_result, !in_ready |-> out_valid)

  `TRD_ASSERT(a_count_range, out_valid |-> repeat_count != 8'd0 && repeat_count <= 8'd128)

  // reset empties the output stage
  `TRD_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid && in_ready)

endmodule

bind tga_rle_row_decoder trd_checker u_trd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .pixel_value  (out_ch.pixel_value),
  .repeat_count (out_ch.repeat_count)
);
